[sv/awu_pkg.sv]
package awu_pkg;

  // field and store widths
  localparam int NUM_WEIGHTS_DEF = 4096;
  localparam int IDX_W    = 12;
  localparam int DATA_W   = 32;
  localparam int M2_W     = 48;
  localparam int PWR_W    = 32;
  localparam int LR_W     = 24;
  localparam int BETA_W   = 16;
  localparam int EPS_W    = 32;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 48;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // shared long divider and square root
  localparam int DIV_N_W   = 80;
  localparam int DIV_D_W   = 41;
  localparam int DIV_Q_W   = 49;
  localparam int DIV_CNT_W = 7;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int SQ_CNT_W  = 5;

  // register reset values
  localparam logic [LR_W-1:0]   LR_RST  = 24'd16777;
  localparam logic [BETA_W-1:0] B1_RST  = 16'd58982;
  localparam logic [BETA_W-1:0] B2_RST  = 16'd65470;
  localparam logic [EPS_W-1:0]  EPS_RST = 32'd43;
  localparam logic [PWR_W-1:0]  PWR_ONE = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_LR  = 2'd0,
    REG_B1  = 2'd1,
    REG_B2  = 2'd2,
    REG_EPS = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_M1A,
    ST_M1B,
    ST_GSQ,
    ST_M2A,
    ST_M2B,
    ST_M2C,
    ST_M2D,
    ST_WB,
    ST_D1,
    ST_D1W,
    ST_D2,
    ST_D2W,
    ST_SQ,
    ST_SQW,
    ST_NUM,
    ST_D3,
    ST_D3W,
    ST_FIN
  } awu_state_t;

endpackage

[sv/awu_div.sv]
// Restoring divider: quotient = min(floor(dividend / divisor), cap).
// One quotient bit per cycle over the whole dividend width.
module awu_div import awu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  input  logic [DIV_Q_W-1:0] cap,
  output logic               done,
  output logic [DIV_Q_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_N_W-1:0]   num_sh;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_Q_W-1:0]   cap_r;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_Q_W:0]     q;
  logic                 sat;

  logic [DIV_D_W:0]     trial;
  logic                 ge;
  logic [DIV_D_W-1:0]   rem_next;
  logic [DIV_Q_W:0]     q_shift;

  // one restoring step
  always_comb begin
    trial    = {rem, num_sh[DIV_N_W-1]};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? DIV_D_W'(trial - {1'b0, dsr}) : trial[DIV_D_W-1:0];
    q_shift  = {q[DIV_Q_W-1:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath; quotient freezes once it passes the cap
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= dividend;
      dsr    <= divisor;
      cap_r  <= cap;
      rem    <= '0;
      q      <= '0;
      sat    <= 1'b0;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_N_W-2:0], 1'b0};
      rem    <= rem_next;
      if (!sat) begin
        q <= q_shift;
        if (q_shift > {1'b0, cap_r}) begin
          sat <= 1'b1;
        end
      end
    end
  end

  assign quotient = sat ? cap_r : q[DIV_Q_W-1:0];

endmodule

[sv/awu_sqrt.sv]
// Integer square root, two radicand bits per cycle.
module awu_sqrt import awu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic                busy;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_W-1:0]     v;
  logic [SQ_W-1:0]     res;
  logic [SQ_W-1:0]     bitv;
  logic [SQ_W-1:0]     sum;
  logic                ge;

  assign sum = res + bitv;
  assign ge  = v >= sum;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQ_CNT_W'(SQ_W / 2 - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (ge) begin
        v   <= v - sum;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = res[ROOT_W-1:0];

endmodule

[sv/adam_weight_update.sv]
// Adam weight update engine, one item in flight at a time.
// An item passes through the index fold, the store read, the multiply and write-back steps,
// three long divisions, a square root, an operand step and the output load. A bias correction
// whose power is still one, or a step with a zero denominator, skips its division. A new
// item is taken only once the last result is in the output register. Reset restores the
// configuration and bias powers, clears control and starts a clearing pass of both stores.
module adam_weight_update import awu_pkg::*; #(
  parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // s_axis_tdata: weight_index[11:0], param_value[43:12], grad_value[75:44], zero pad
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // s_axis_tuser: step_start
  input  logic                 s_axis_tuser,
  // m_axis_tdata: new_param[31:0], out_index[43:32], zero pad
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int SLOT_W = $clog2(NUM_WEIGHTS);
  localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(NUM_WEIGHTS - 1);

  // reciprocal for the index fold, exact floor(index / NUM_WEIGHTS) for every index
  localparam int RSH    = IDX_W + SLOT_W;
  localparam int RCP_W  = IDX_W + 2;
  localparam int PROD_W = IDX_W + RCP_W;
  localparam longint RCP_L = ((longint'(1) << RSH) + longint'(NUM_WEIGHTS) - 1)
                             / longint'(NUM_WEIGHTS);
  localparam logic [RCP_W-1:0] RCP    = RCP_W'(RCP_L);
  localparam logic [IDX_W-1:0] NW_LOW = IDX_W'(NUM_WEIGHTS);

  awu_state_t state, state_next;

  // configuration
  logic [LR_W-1:0]   step_size;
  logic [BETA_W-1:0] first_decay;
  logic [BETA_W-1:0] second_decay;
  logic [EPS_W-1:0]  stabiliser;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  // item registers
  logic [IDX_W-1:0]        idx_q;
  logic signed [DATA_W-1:0] param_q;
  logic signed [DATA_W-1:0] grad_q;
  logic                    start_q;
  logic                    mod_ph;
  logic [IDX_W-1:0]        quot;
  logic [PROD_W-1:0]       rcp_prod;
  logic [IDX_W-1:0]        qmul;
  logic [IDX_W-1:0]        fold;
  logic [SLOT_W-1:0]       slot;

  // store and clearing pass
  logic [DATA_W-1:0] m1_mem [NUM_WEIGHTS];
  logic [M2_W-1:0]   m2_mem [NUM_WEIGHTS];
  logic [DATA_W-1:0] m1_rd;
  logic [M2_W-1:0]   m2_rd;
  logic              clearing;
  logic [SLOT_W-1:0] clr_cnt;
  logic              mem_we;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_addr;

  // arithmetic registers
  logic [PWR_W-1:0]         p1;
  logic [PWR_W-1:0]         p2;
  logic signed [49:0]       acc1;
  logic [DATA_W-1:0]        m1_r;
  logic [46:0]              gsq;
  logic [63:0]              acc2;
  logic [M2_W-1:0]          m2_r;
  logic                     m1_neg;
  logic [DATA_W-1:0]        m1_mag;
  logic [DATA_W-1:0]        m1h_mag;
  logic [M2_W-1:0]          m2h;
  logic [55:0]              num_r;
  logic [DIV_D_W-1:0]       den_r;
  logic [33:0]              step;

  // derived values
  logic signed [17:0]       b1_s;
  logic signed [17:0]       c1_s;
  logic signed [DATA_W-1:0] m1_rd_s;
  logic [16:0]              c2;
  logic [DATA_W-1:0]        gmag;
  logic [63:0]              gprod;
  logic [PWR_W-1:0]         d1;
  logic [PWR_W-1:0]         d2;
  logic signed [35:0]       np_wide;
  logic signed [DATA_W-1:0] np;

  // unit handshakes
  logic               div_start;
  logic               div_done;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_Q_W-1:0] div_cap;
  logic [DIV_Q_W-1:0] div_q;
  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic               out_free;
  logic               in_beat;

  // positive moment magnitudes above the signed range stop at the maximum
  function automatic logic [DATA_W-1:0] clamp_pos(input logic neg, input logic [DATA_W-1:0] mag);
    if (!neg && mag > 32'h7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return mag;
  endfunction

  // APB register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= LR_RST;
      first_decay  <= B1_RST;
      second_decay <= B2_RST;
      stabiliser   <= EPS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LR:  step_size    <= pwdata[LR_W-1:0];
        REG_B1:  first_decay  <= pwdata[BETA_W-1:0];
        REG_B2:  second_decay <= pwdata[BETA_W-1:0];
        REG_EPS: stabiliser   <= pwdata[EPS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_LR:  prdata = APB_DW'(step_size);
      REG_B1:  prdata = APB_DW'(first_decay);
      REG_B2:  prdata = APB_DW'(second_decay);
      REG_EPS: prdata = APB_DW'(stabiliser);
    endcase
  end

  // derived operands
  always_comb begin
    b1_s      = $signed({2'b00, first_decay});
    c1_s      = 18'sd65536 - b1_s;
    m1_rd_s   = $signed(m1_rd);
    c2        = 17'd65536 - {1'b0, second_decay};
    gmag      = grad_q[DATA_W-1] ? DATA_W'(~grad_q + 1'b1) : grad_q;
    gprod     = gmag * gmag;
    d1        = PWR_ONE - p1;
    d2        = PWR_ONE - p2;
    rcp_prod  = PROD_W'(idx_q) * PROD_W'(RCP);
    qmul      = IDX_W'(quot * NW_LOW);
    fold      = idx_q - qmul;
    np_wide   = m1_neg ? 36'(param_q) + $signed({2'b00, step})
                       : 36'(param_q) - $signed({2'b00, step});
    if (np_wide > 36'sd2147483647) begin
      np = 32'sh7FFF_FFFF;
    end else if (np_wide < -36'sd2147483648) begin
      np = 32'sh8000_0000;
    end else begin
      np = np_wide[DATA_W-1:0];
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_beat) state_next = ST_MOD;
      ST_MOD:  if (mod_ph) state_next = ST_READ;
      ST_READ: state_next = ST_M1A;
      ST_M1A:  state_next = ST_M1B;
      ST_M1B:  state_next = ST_GSQ;
      ST_GSQ:  state_next = ST_M2A;
      ST_M2A:  state_next = ST_M2B;
      ST_M2B:  state_next = ST_M2C;
      ST_M2C:  state_next = ST_M2D;
      ST_M2D:  state_next = ST_WB;
      ST_WB:   state_next = ST_D1;
      ST_D1:   state_next = (d1 == '0) ? ST_D2 : ST_D1W;
      ST_D1W:  if (div_done) state_next = ST_D2;
      ST_D2:   state_next = (d2 == '0) ? ST_SQ : ST_D2W;
      ST_D2W:  if (div_done) state_next = ST_SQ;
      ST_SQ:   state_next = ST_SQW;
      ST_SQW:  if (sq_done) state_next = ST_NUM;
      ST_NUM:  state_next = ST_D3;
      ST_D3:   state_next = (den_r == '0) ? ST_FIN : ST_D3W;
      ST_D3W:  if (div_done) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !clearing;
    mem_re        = (state == ST_READ);
    mem_we        = clearing || (state == ST_WB);
    mem_addr      = clearing ? clr_cnt : slot;
    sq_start      = (state == ST_SQ);
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    div_cap       = '0;
    unique case (state)
      ST_D1: begin
        div_start    = d1 != '0;
        div_dividend = {17'b0, m1_mag, 31'b0};
        div_divisor  = {9'b0, d1};
        div_cap      = DIV_Q_W'(64'h8000_0000);
      end
      ST_D1W: begin
        div_cap = DIV_Q_W'(64'h8000_0000);
      end
      ST_D2: begin
        div_start    = d2 != '0;
        div_dividend = {1'b0, m2_r, 31'b0};
        div_divisor  = {9'b0, d2};
        div_cap      = {1'b0, {M2_W{1'b1}}};
      end
      ST_D3: begin
        div_start    = den_r != '0;
        div_dividend = {16'b0, num_r, 8'b0};
        div_divisor  = den_r;
        div_cap      = DIV_Q_W'(64'h2_0000_0000);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass over both stores after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == SLOT_END) begin
        clearing <= 1'b0;
      end
    end
  end

  // moment stores, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      m1_mem[mem_addr] <= clearing ? '0 : m1_r;
    end
    if (mem_re) begin
      m1_rd <= m1_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m2_mem[mem_addr] <= clearing ? '0 : acc2[63:16];
    end
    if (mem_re) begin
      m2_rd <= m2_mem[slot];
    end
  end

  // bias correction powers
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= PWR_ONE;
      p2 <= PWR_ONE;
    end else begin
      if (state == ST_M1A && start_q) begin
        p1 <= PWR_W'((p1 * first_decay + 48'd32768) >> 16);
      end
      if (state == ST_M1B && start_q) begin
        p2 <= PWR_W'((p2 * second_decay + 48'd32768) >> 16);
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx_q   <= s_axis_tdata[IDX_W-1:0];
        param_q <= s_axis_tdata[43:12];
        grad_q  <= s_axis_tdata[75:44];
        start_q <= s_axis_tuser;
        mod_ph  <= 1'b0;
      end
      ST_MOD: begin
        // index modulo store depth: reciprocal quotient, then remainder
        mod_ph <= 1'b1;
        if (!mod_ph) begin
          quot <= IDX_W'(rcp_prod >> RSH);
        end else begin
          slot <= SLOT_W'(fold);
        end
      end
      ST_READ: begin
        slot <= slot;
      end
      ST_M1A: begin
        acc1 <= 50'(b1_s * m1_rd_s) + 50'sd32768;
      end
      ST_M1B: begin
        acc1 <= acc1 + 50'(c1_s * grad_q);
      end
      ST_GSQ: begin
        m1_r <= acc1[47:16];
        gsq  <= 47'((gprod + 64'd32768) >> 16);
      end
      ST_M2A: begin
        acc2 <= 64'(second_decay * m2_rd[23:0]) + 64'd32768;
      end
      ST_M2B: begin
        acc2 <= acc2 + (64'(second_decay * m2_rd[47:24]) << 24);
      end
      ST_M2C: begin
        acc2 <= acc2 + 64'(c2 * gsq[23:0]);
      end
      ST_M2D: begin
        acc2 <= acc2 + (64'(c2 * gsq[46:24]) << 24);
      end
      ST_WB: begin
        m2_r   <= acc2[63:16];
        m1_neg <= m1_r[DATA_W-1];
        m1_mag <= m1_r[DATA_W-1] ? DATA_W'(~m1_r + 1'b1) : m1_r;
      end
      ST_D1: begin
        m1h_mag <= clamp_pos(m1_neg, m1_mag);
      end
      ST_D1W: begin
        if (div_done) begin
          m1h_mag <= clamp_pos(m1_neg, div_q[DATA_W-1:0]);
        end
      end
      ST_D2: begin
        m2h <= m2_r;
      end
      ST_D2W: begin
        if (div_done) begin
          m2h <= div_q[M2_W-1:0];
        end
      end
      ST_NUM: begin
        num_r <= m1h_mag * step_size;
        den_r <= {1'b0, sq_root, 8'b0} + DIV_D_W'(stabiliser);
      end
      ST_D3: begin
        step <= '0;
      end
      ST_D3W: begin
        if (div_done) begin
          step <= div_q[33:0];
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= {4'b0, idx_q, np};
    end
  end

  awu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .cap      (div_cap),
    .done     (div_done),
    .quotient (div_q)
  );

  awu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({m2h, 16'b0}),
    .done     (sq_done),
    .root     (sq_root)
  );

endmodule

[sv/awu_checker.sv]
module awu_checker import awu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [APB_AW-1:0]    paddr,
  input logic [APB_DW-1:0]    pwdata,
  input logic [APB_DW-1:0]    prdata,
  input logic                 pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // the stores are being cleared right after reset
  a_clear: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input taken during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  // a result cannot appear the cycle after its item arrives
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  a_ready: assert property (@(posedge clk) pready)
    else $error("config port not ready");

endmodule

bind adam_weight_update awu_checker u_awu_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import awu_pkg::*;

  localparam int NW = NUM_WEIGHTS_DEF;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // s_axis_tdata: weight_index[11:0], param_value[43:12], grad_value[75:44], zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // s_axis_tuser: step_start
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // m_axis_tdata: new_param[31:0], out_index[43:32], zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  adam_weight_update dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [31:0] new_param;
    logic [11:0] index;
  } update_t;

  // shadow of the engine state
  logic signed [31:0] m1_mem [NW];
  logic [47:0]        m2_mem [NW];
  logic [31:0]        pow1, pow2;
  logic [LR_W-1:0]    lr_q;
  logic [BETA_W-1:0]  b1_q, b2_q;
  logic [EPS_W-1:0]   eps_q;

  update_t pending_updates[$];
  int      n_errors;
  int      burst_left;
  int      rdy_mode;

  // floor(n / d) clipped at cap
  function automatic logic [127:0] div_clip(logic [127:0] n, logic [127:0] d,
                                            logic [127:0] cap);
    logic [127:0] q;
    q = n / d;
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [127:0] res;
    logic [127:0] t;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (128'd1 << b);
      if (t * t <= {64'd0, v}) res = t;
    end
    return res[63:0];
  endfunction

  // one Adam element update against the shadow state
  function automatic update_t adam_update(logic [11:0] idx, logic signed [31:0] prm,
                                          logic signed [31:0] grd, logic start);
    update_t      r;
    int           slot;
    longint       g, b1l, s1, m1, np;
    logic [63:0]  gmag, gsq, m1mag, root;
    logic [79:0]  acc;
    logic [127:0] m2, m2hat, d1, d2, den, num, stp, pw;
    logic         neg;
    slot = idx % NW;
    if (start) begin
      pw = ({96'd0, pow1} * b1_q + 32768) >> 16;
      pow1 = pw[31:0];
      pw = ({96'd0, pow2} * b2_q + 32768) >> 16;
      pow2 = pw[31:0];
    end
    g = grd;
    b1l = b1_q;
    s1 = b1l * longint'(m1_mem[slot]) + (65536 - b1l) * g + 32768;
    m1 = s1 >>> 16;
    m1_mem[slot] = m1[31:0];
    gmag = (g < 0) ? -g : g;
    gsq = (gmag * gmag + 64'd32768) >> 16;
    acc = {64'd0, b2_q} * m2_mem[slot] + (80'd65536 - b2_q) * gsq + 80'd32768;
    acc = acc >> 16;
    m2 = {80'd0, acc[47:0]};
    m2_mem[slot] = acc[47:0];
    // bias correction; power still one leaves a moment uncorrected
    neg = m1 < 0;
    m1mag = neg ? -m1 : m1;
    d1 = 128'h8000_0000 - pow1;
    if (d1 != 0) m1mag = div_clip({64'd0, m1mag} << 31, d1, 128'h8000_0000);
    if (!neg && m1mag > 64'h7FFF_FFFF) m1mag = 64'h7FFF_FFFF;
    d2 = 128'h8000_0000 - pow2;
    m2hat = m2;
    if (d2 != 0) m2hat = div_clip(m2 << 31, d2, 128'hFFFF_FFFF_FFFF);
    root = int_root(m2hat[63:0] << 16);
    den = ({64'd0, root} << 8) + eps_q;
    np = prm;
    // zero denominator leaves the weight unchanged
    if (den != 0) begin
      num = {64'd0, m1mag} * lr_q;
      stp = div_clip(num << 8, den, 128'd1 << 33);
      np = neg ? np + longint'(stp[63:0]) : np - longint'(stp[63:0]);
      if (np > 64'sd2147483647) np = 64'sd2147483647;
      if (np < -64'sd2147483648) np = -64'sd2147483648;
    end
    r.new_param = np[31:0];
    r.index = idx;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // input beats feed the predictor, output beats are checked
  always @(posedge clk) begin
    update_t e;
    if (!rst && s_axis_tvalid && s_axis_tready)
      pending_updates.push_back(adam_update(s_axis_tdata[11:0], s_axis_tdata[43:12],
                                            s_axis_tdata[75:44], s_axis_tuser));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        e = pending_updates.pop_front();
        if (m_axis_tdata[31:0] !== e.new_param || m_axis_tdata[43:32] !== e.index) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch idx exp %0d got %0d, param exp %h got %h",
                     e.index, m_axis_tdata[43:32], e.new_param, m_axis_tdata[31:0]);
        end
      end
    end
  end

  // receiver stall pattern, mode changes at random
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready = 1'b1;
    end else begin
      if ($urandom_range(0, 299) == 0) rdy_mode = $urandom_range(0, 2);
      case (rdy_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = ($urandom_range(0, 3) != 0);
        default: m_axis_tready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic reg_write(cfg_reg_t r, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = APB_AW'(4 * int'(r)); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (r)
      REG_LR:  lr_q = v[LR_W-1:0];
      REG_B1:  b1_q = v[BETA_W-1:0];
      REG_B2:  b2_q = v[BETA_W-1:0];
      REG_EPS: eps_q = v;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_weight(logic [11:0] idx, logic [31:0] prm, logic [31:0] grd,
                             logic start);
    logic rdy;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 6);
    end
    burst_left--;
    s_axis_tdata = {4'd0, grd, prm, idx};
    s_axis_tuser = start;
    s_axis_tvalid = 1'b1;
    forever begin
      #1 rdy = s_axis_tready;
      @(posedge clk);
      @(negedge clk);
      if (rdy) break;
    end
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (320) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
      default: return 32'($signed($urandom_range(0, 1048575)) - 524288);
    endcase
  endfunction

  // defaults, power still one, field extremes
  task automatic test_directed;
    send_weight(12'd0, 32'h0100_0000, 32'h0010_0000, 1'b0);
    send_weight(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_weight(12'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_weight(12'd2, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_weight(12'd0, 32'h0100_0000, 32'hFFF0_0000, 1'b1);
    send_weight(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_weight(12'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_weight(12'd2730, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_weight(12'd1365, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_weight(12'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    drain();
  endtask

  // zero denominator: eps cleared and two untouched entries with zero gradient
  task automatic test_zero_den;
    reg_write(REG_EPS, 32'd0);
    send_weight(12'd3000, 32'h1234_5678, 32'd0, 1'b0);
    send_weight(12'd3001, 32'h8765_4321, 32'd0, 1'b1);
    drain();
  endtask

  // random items under one register setting
  task automatic test_random(int n, logic [31:0] lr, logic [31:0] b1,
                             logic [31:0] b2, logic [31:0] eps);
    logic [11:0] idx;
    reg_write(REG_LR, lr);
    reg_write(REG_B1, b1);
    reg_write(REG_B2, b2);
    reg_write(REG_EPS, eps);
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 15));
      send_weight(idx, $urandom(), rand_grad(), $urandom_range(0, 7) == 0);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
    m_axis_tready = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    n_errors = 0; burst_left = 0; rdy_mode = 0;
    for (int i = 0; i < NW; i++) begin
      m1_mem[i] = '0;
      m2_mem[i] = '0;
    end
    pow1 = PWR_ONE; pow2 = PWR_ONE;
    lr_q = LR_RST; b1_q = B1_RST; b2_q = B2_RST; eps_q = EPS_RST;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_zero_den();
    test_random(400, 32'd16777, 32'd58982, 32'd65470, 32'd43);
    test_random(300, 32'hFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
    test_random(300, 32'd0, 32'd0, 32'd0, 32'd0);
    test_random(300, 32'h00_1000, 32'd32768, 32'd60000, 32'd1);
    test_random(300, $urandom(), $urandom(), $urandom(), $urandom());
    test_random(300, 32'd167772, 32'd58982, 32'hFFFF, 32'd0);

    drain();
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
